// ===== src/nrcm_pkg.sv =====
// ----------------------------------------------------------------------------
// nrcm_pkg
// Shared types and constants of the regex capture matcher.
// ----------------------------------------------------------------------------
package nrcm_pkg;

  localparam int MaxStates  = 64;
  localparam int MaxSlots   = 16;
  localparam int PosBits    = 16;
  localparam int StackDepth = MaxStates + 1;
  localparam int StW        = $clog2(MaxStates);
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int ThrIdxW    = StW + 1;

  localparam logic [1:0] ReqLoad = 2'd0;
  localparam logic [1:0] ReqText = 2'd1;
  localparam logic [1:0] ReqEnd  = 2'd2;

  localparam logic [2:0] KindChar  = 3'd0;
  localparam logic [2:0] KindAny   = 3'd1;
  localparam logic [2:0] KindSplit = 3'd2;
  localparam logic [2:0] KindSave  = 3'd3;
  localparam logic [2:0] KindMatch = 3'd4;

  localparam logic CfgStart = 1'b0;
  localparam logic CfgCount = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [5:0] nxt;
    logic [5:0] alt;
    logic [3:0] slot;
  } prog_t;

  typedef struct packed {
    logic               set;
    logic [PosBits-1:0] pos;
  } cell_t;

  typedef cell_t [MaxSlots-1:0] caps_t;

  typedef struct packed {
    logic [StW-1:0] st;
    caps_t          caps;
  } thr_t;

  typedef struct packed {
    logic [1:0] req;
    logic [5:0] idx;
    prog_t      entry;
    logic [7:0] tchar;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_SEEDPUSH, ST_TFETCH, ST_TPROG, ST_TTEST, ST_CPOP,
    ST_CCHK, ST_CEXEC, ST_CPUSH2, ST_PROMOTE, ST_EFETCH, ST_EPROG, ST_ETEST,
    ST_EOUT
  } state_e;

endpackage

// ===== src/nrcm_front.sv =====
// ----------------------------------------------------------------------------
// nrcm_front
// Input stage: accepts stream items, drops unknown kinds, queues commands.
// ----------------------------------------------------------------------------
module nrcm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  output logic                 cmd_valid_o,
  output nrcm_pkg::cmd_t       cmd_o,
  input  logic                 cmd_pop_i
);
  import nrcm_pkg::*;

  cmd_t       q_mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.req        = s_axis_tuser;
    in_cmd.idx        = s_axis_tdata[5:0];
    in_cmd.entry.kind = s_axis_tdata[8:6];
    in_cmd.entry.ch   = s_axis_tdata[16:9];
    in_cmd.entry.nxt  = s_axis_tdata[22:17];
    in_cmd.entry.alt  = s_axis_tdata[28:23];
    in_cmd.entry.slot = s_axis_tdata[32:29];
    in_cmd.tchar      = s_axis_tdata[40:33];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  // drop the unused request code at the door
  assign push          = s_axis_tvalid && s_axis_tready && (s_axis_tuser != 2'd3);
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = q_mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (cmd_pop_i && cmd_valid_o) begin
      rd_d = ~rd_q;
    end
    case ({push, cmd_pop_i && cmd_valid_o})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= in_cmd;
    end
  end

endmodule

// ===== src/nrcm_engine.sv =====
// ----------------------------------------------------------------------------
// nrcm_engine
// Pike VM sequencer: thread lists, depth-first closure stack, result output.
// ----------------------------------------------------------------------------
module nrcm_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  nrcm_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [5:0]           cfg_data_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,
  output logic                 m_axis_tlast
);
  import nrcm_pkg::*;

  state_e state_q, state_d;

  prog_t prog_mem [MaxStates];
  thr_t  thr_mem  [2*MaxStates];
  thr_t  stk_mem  [StackDepth];
  prog_t prog_rd_q;
  thr_t  thr_rd_q, stk_rd_q;

  logic [StW-1:0]     start_q;
  logic [4:0]         ccount_q;
  logic [MaxStates-1:0] visit_q, visit_d;
  logic               cb_q, cb_d;
  logic [ThrIdxW-1:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d, i_q, i_d;
  logic [SpW-1:0]     sp_q, sp_d;
  logic [PosBits:0]   pos_q, pos_d;
  logic               active_q, active_d;
  logic               seed_q, seed_d;
  logic [StW-1:0]     cst_q, cst_d;
  caps_t              cur_q, cur_d;
  logic               found_q, found_d;
  caps_t              fcaps_q, fcaps_d;
  logic [3:0]         k_q, k_d;

  logic               push_en;
  logic [StW-1:0]     push_st;
  caps_t              push_caps;
  logic               thr_we;
  logic [StW-1:0]     prog_raddr;
  logic [SpW-1:0]     stk_raddr;
  logic [4:0]         n_use;
  logic [PosBits:0]   after;
  logic [PosBits-1:0] save_pos;
  caps_t              saved;
  logic               char_hit;
  cell_t              out_cell;
  logic               out_last;

  assign cfg_ready_o = 1'b1;
  assign n_use       = (ccount_q > 5'(MaxSlots)) ? 5'(MaxSlots) : ccount_q;
  assign after       = pos_q + (PosBits+1)'(1);
  assign save_pos    = seed_q ? '0 : (after[PosBits] ? '1 : after[PosBits-1:0]);
  assign char_hit    = ((prog_rd_q.kind == KindChar) && (prog_rd_q.ch == cmd_i.tchar))
                       || (prog_rd_q.kind == KindAny);
  // hold the popped entry through execute so a split still sees it on its second push
  assign prog_raddr  = (state_q == ST_CCHK)  ? stk_rd_q.st :
                       (state_q == ST_CEXEC) ? cst_q : thr_rd_q.st;
  assign stk_raddr   = sp_q - SpW'(1);

  always_comb begin
    saved = cur_q;
    if ({1'b0, prog_rd_q.slot} < n_use) begin
      saved[prog_rd_q.slot].set = 1'b1;
      saved[prog_rd_q.slot].pos = save_pos;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.req == ReqLoad) begin
            state_d = ST_IDLE;
          end else if (!active_q) begin
            state_d = ST_SEED;
          end else if (cmd_i.req == ReqText) begin
            state_d = ST_TFETCH;
          end else begin
            state_d = ST_EFETCH;
          end
        end
      end
      ST_SEED:     state_d = ST_SEEDPUSH;
      ST_SEEDPUSH: state_d = ST_CPOP;
      ST_TFETCH:   state_d = (i_q >= cnt0_q) ? ST_PROMOTE : ST_TPROG;
      ST_TPROG:    state_d = ST_TTEST;
      ST_TTEST:    state_d = char_hit ? ST_CPOP : ST_TFETCH;
      ST_CPOP: begin
        if (sp_q != '0) begin
          state_d = ST_CCHK;
        end else if (seed_q) begin
          state_d = ST_PROMOTE;
        end else begin
          state_d = ST_TFETCH;
        end
      end
      ST_CCHK:     state_d = visit_q[stk_rd_q.st] ? ST_CPOP : ST_CEXEC;
      ST_CEXEC:    state_d = (prog_rd_q.kind == KindSplit) ? ST_CPUSH2 : ST_CPOP;
      ST_CPUSH2:   state_d = ST_CPOP;
      ST_PROMOTE:  state_d = ST_IDLE;
      ST_EFETCH:   state_d = (i_q >= cnt0_q) ? ST_EOUT : ST_EPROG;
      ST_EPROG:    state_d = ST_ETEST;
      ST_ETEST:    state_d = (prog_rd_q.kind == KindMatch) ? ST_EOUT : ST_EFETCH;
      ST_EOUT:     state_d = (m_axis_tready && out_last) ? ST_IDLE : ST_EOUT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    visit_d   = visit_q;
    cb_d      = cb_q;
    cnt0_d    = cnt0_q;
    cnt1_d    = cnt1_q;
    i_d       = i_q;
    sp_d      = sp_q;
    pos_d     = pos_q;
    active_d  = active_q;
    seed_d    = seed_q;
    cst_d     = cst_q;
    cur_d     = cur_q;
    found_d   = found_q;
    fcaps_d   = fcaps_q;
    k_d       = k_q;
    push_en   = 1'b0;
    push_st   = '0;
    push_caps = cur_q;
    thr_we    = 1'b0;
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.req == ReqLoad) begin
            cmd_pop_o = 1'b1;
          end else if (active_q) begin
            visit_d = '0;
            cnt1_d  = '0;
            i_d     = '0;
            seed_d  = 1'b0;
          end
        end
      end
      ST_SEED: begin
        visit_d = '0;
        cnt1_d  = '0;
        pos_d   = '0;
        sp_d    = '0;
        seed_d  = 1'b1;
      end
      ST_SEEDPUSH: begin
        push_en   = 1'b1;
        push_st   = start_q;
        push_caps = '0;
      end
      ST_TFETCH: begin
        if (i_q >= cnt0_q) begin
          seed_d = 1'b0;
        end
      end
      ST_TTEST: begin
        if (char_hit) begin
          push_en   = 1'b1;
          push_st   = prog_rd_q.nxt;
          push_caps = thr_rd_q.caps;
        end else begin
          i_d = i_q + ThrIdxW'(1);
        end
      end
      ST_CPOP: begin
        if (sp_q != '0) begin
          sp_d = sp_q - SpW'(1);
        end else if (!seed_q) begin
          i_d = i_q + ThrIdxW'(1);
        end
      end
      ST_CCHK: begin
        cst_d = stk_rd_q.st;
        cur_d = stk_rd_q.caps;
        if (!visit_q[stk_rd_q.st]) begin
          visit_d[stk_rd_q.st] = 1'b1;
        end
      end
      ST_CEXEC: begin
        case (prog_rd_q.kind)
          KindSplit: begin
            push_en = 1'b1;
            push_st = prog_rd_q.alt;
          end
          KindSave: begin
            push_en   = 1'b1;
            push_st   = prog_rd_q.nxt;
            push_caps = saved;
          end
          default: begin
            if (cnt1_q < ThrIdxW'(MaxStates)) begin
              thr_we = 1'b1;
              cnt1_d = cnt1_q + ThrIdxW'(1);
            end
          end
        endcase
      end
      ST_CPUSH2: begin
        push_en = 1'b1;
        push_st = prog_rd_q.nxt;
      end
      ST_PROMOTE: begin
        cb_d   = ~cb_q;
        cnt0_d = cnt1_q;
        cnt1_d = '0;
        if (seed_q) begin
          active_d = 1'b1;
        end else begin
          pos_d     = pos_q[PosBits] ? pos_q : after;
          cmd_pop_o = 1'b1;
        end
      end
      ST_EFETCH: begin
        k_d = '0;
        if (i_q >= cnt0_q) begin
          found_d = 1'b0;
        end
      end
      ST_ETEST: begin
        if (prog_rd_q.kind == KindMatch) begin
          found_d = 1'b1;
          fcaps_d = thr_rd_q.caps;
        end else begin
          i_d = i_q + ThrIdxW'(1);
        end
      end
      ST_EOUT: begin
        if (m_axis_tready) begin
          if (out_last) begin
            cmd_pop_o = 1'b1;
            active_d  = 1'b0;
            cnt0_d    = '0;
            cnt1_d    = '0;
            pos_d     = '0;
          end else begin
            k_d = k_q + 4'd1;
          end
        end
      end
      default: begin
        cb_d = cb_q;
      end
    endcase
    // drop pushes onto visited entries or a full stack
    if (push_en && (visit_q[push_st] || (sp_q >= SpW'(StackDepth)))) begin
      push_en = 1'b0;
    end
    if (push_en) begin
      sp_d = sp_q + SpW'(1);
    end
  end

  // result formatting
  always_comb begin
    out_cell = fcaps_q[k_q];
    if (!found_q || (n_use == '0) || !out_cell.set) begin
      out_cell = '0;
    end
    out_last      = (n_use == '0) || ({1'b0, k_q} + 5'd1 == n_use);
    m_axis_tvalid = (state_q == ST_EOUT);
    m_axis_tlast  = out_last;
    m_axis_tdata  = {1'b0, pos_q[PosBits], out_cell.pos, out_cell.set, k_q, found_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      start_q  <= '0;
      ccount_q <= '0;
      visit_q  <= '0;
      cb_q     <= 1'b0;
      cnt0_q   <= '0;
      cnt1_q   <= '0;
      i_q      <= '0;
      sp_q     <= '0;
      pos_q    <= '0;
      active_q <= 1'b0;
      seed_q   <= 1'b0;
      found_q  <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      visit_q  <= visit_d;
      cb_q     <= cb_d;
      cnt0_q   <= cnt0_d;
      cnt1_q   <= cnt1_d;
      i_q      <= i_d;
      sp_q     <= sp_d;
      pos_q    <= pos_d;
      active_q <= active_d;
      seed_q   <= seed_d;
      found_q  <= found_d;
      k_q      <= k_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgStart: start_q  <= cfg_data_i[StW-1:0];
          CfgCount: ccount_q <= cfg_data_i[4:0];
          default:  start_q  <= start_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cst_q    <= cst_d;
    cur_q    <= cur_d;
    fcaps_q  <= fcaps_d;
    prog_rd_q <= prog_mem[prog_raddr];
    thr_rd_q  <= thr_mem[{cb_q, i_q[StW-1:0]}];
    stk_rd_q  <= stk_mem[stk_raddr];
    if ((state_q == ST_IDLE) && cmd_valid_i && (cmd_i.req == ReqLoad)) begin
      prog_mem[cmd_i.idx] <= cmd_i.entry;
    end
    if (thr_we) begin
      thr_mem[{~cb_q, cnt1_q[StW-1:0]}] <= '{st: cst_q, caps: cur_q};
    end
    if (push_en) begin
      stk_mem[sp_q] <= '{st: push_st, caps: push_caps};
    end
  end

endmodule

// ===== src/nfa_regex_capture_matcher_core.sv =====
// ----------------------------------------------------------------------------
// nfa_regex_capture_matcher_core
// Pike VM regex matcher with capture slots, stream in and stream out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries load, text and end-of-text items (tuser = request type).
//   Load items write the 64-entry program; text items step every live thread
//   through its depth-first closure; an end item emits one result per capture
//   slot in use (one result if none), tlast on the final one.
//   cfg writes start_state (index 0) and capture_count (index 1); the user
//   must do so only while idle, as the block itself does not enforce this.
// Processing:
//   A text item tests each live thread's entry in turn and, on a hit, walks
//   the closure of its next state depth-first; an end item scans the threads
//   for a match, then gives one result per cycle while m_axis_tready is high.
//   The first item of a string adds the start closure first.
// Reset: clears thread counts, visit marks, position and string state; the
//   program memory holds garbage until loaded.
// Stall: a waiting result holds; a two-item input queue accepts until full.
// ----------------------------------------------------------------------------
module nfa_regex_capture_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index, entry_kind, entry_char, entry_next, entry_alt, entry_slot,
  // text_char, zero fill
  input  logic [47:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // matched, slot_number, slot_set, slot_position, position_overflow, zero fill
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import nrcm_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  nrcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  nrcm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== src/nrcm_checker.sv =====
// ----------------------------------------------------------------------------
// nrcm_checker
// Port-level checks on the matcher's result stream.
// ----------------------------------------------------------------------------
module nrcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_set_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[0])
    else $error("slot set without a match");

  a_unset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[5] |-> (m_axis_tdata[21:6] == 16'd0))
    else $error("unset slot carries a position");

endmodule

bind nfa_regex_capture_matcher_core nrcm_checker u_nrcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
